>>> src/tbbp_pkg.sv
// ----------------------------------------------------------------------------
// tbbp_pkg
// Shared types and constants of the two-bit bimodal branch predictor.
// ----------------------------------------------------------------------------
`default_nettype none

package tbbp_pkg;

   // table geometry
   localparam int INDEX_BITS  = 12;
   localparam int TABLE_DEPTH = 1 << INDEX_BITS;

   // field widths
   localparam int ADDR_BITS     = 12;
   localparam int STATE_BITS    = 2;
   localparam int MAP_BITS      = 4;
   localparam int INTERVAL_BITS = 16;
   localparam int TOTAL_BITS    = 32;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [STATE_BITS-1:0] COUNTER_MAX = 2'd3;
   localparam logic [STATE_BITS-1:0] COUNTER_MIN = 2'd0;

   // register reset values
   localparam logic [STATE_BITS-1:0]    FRESH_STATE_RST     = 2'd1;
   localparam logic [MAP_BITS-1:0]      OUTPUT_MAP_RST      = 4'd12;
   localparam logic [INTERVAL_BITS-1:0] INTERVAL_LENGTH_RST = 16'd1024;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_FRESH_STATE     = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_OUTPUT_MAP      = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_INTERVAL_LENGTH = 2'd2;

   // item kinds
   localparam logic KIND_BRANCH  = 1'b0;
   localparam logic KIND_RESTART = 1'b1;

   // result queue
   localparam int RSP_DEPTH    = 3;
   localparam int RSP_PTR_BITS = 2;

   typedef struct packed {
      logic                     prediction;
      logic                     mispredicted;
      logic [TOTAL_BITS-1:0]    total_branches;
      logic [TOTAL_BITS-1:0]    total_misses;
      logic                     interval_done;
      logic [INTERVAL_BITS-1:0] interval_misses;
   } rsp_item_type;

   // table word: entry valid bit above the counter
   typedef struct packed {
      logic                  valid;
      logic [STATE_BITS-1:0] state;
   } entry_type;

endpackage

`default_nettype wire

>>> src/tbbp_channels.sv
// ----------------------------------------------------------------------------
// tbbp channels
// Valid/ready channel interfaces for branch items, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface tbbp_req_if;
   logic                             valid;
   logic                             ready;
   logic                             kind;
   logic [tbbp_pkg::ADDR_BITS-1:0]   branch_address_low;
   logic                             taken;

   modport source (output valid, kind, branch_address_low, taken, input ready);
   modport sink   (input valid, kind, branch_address_low, taken, output ready);
endinterface

interface tbbp_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 prediction;
   logic                                 mispredicted;
   logic [tbbp_pkg::TOTAL_BITS-1:0]      total_branches;
   logic [tbbp_pkg::TOTAL_BITS-1:0]      total_misses;
   logic                                 interval_done;
   logic [tbbp_pkg::INTERVAL_BITS-1:0]   interval_misses;

   modport source (output valid, prediction, mispredicted, total_branches, total_misses,
                   interval_done, interval_misses, input ready);
   modport sink   (input valid, prediction, mispredicted, total_branches, total_misses,
                   interval_done, interval_misses, output ready);
endinterface

interface tbbp_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [tbbp_pkg::CSR_IDX_BITS-1:0]    index;
   logic [tbbp_pkg::CSR_DATA_BITS-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> src/two_bit_branch_predictor_unit.sv
// ----------------------------------------------------------------------------
// two_bit_branch_predictor_unit
// Bimodal predictor: table of 2-bit saturating counters plus miss statistics.
//
// req carries one resolved branch or a restart per item; rsp returns exactly
// one result item per request item, in order; csr writes fresh_state (0),
// output_map (1) and interval_length (2), one write per cycle, always ready.
// The counter table sits in one synchronous RAM: the read is issued when an
// item is accepted, the next cycle computes prediction and update and writes
// the entry back, with a one-entry forward covering back-to-back items on the
// same entry. A result passes the update stage and result queue before rsp;
// one item per cycle is sustained unless rsp stalls or a clearing pass runs,
// set by the single RAM write port. A three-item result queue decouples the
// sides: while rsp is stalled req still takes three items, then drops ready.
// After reset, and after each restart item, a clearing pass writes every one
// of the 4096 table entries, one per cycle; req.ready is low during it and in
// the cycle the restart spends in the update stage (the restart's own result
// is still delivered). Registers return to their reset values on reset.
// ----------------------------------------------------------------------------
`default_nettype none

module two_bit_branch_predictor_unit (
   input  wire        clock,
   input  wire        reset,
   tbbp_req_if.sink   req,
   tbbp_rsp_if.source rsp,
   tbbp_csr_if.sink   csr
);

   localparam int IB = tbbp_pkg::INDEX_BITS;
   localparam int SB = tbbp_pkg::STATE_BITS;
   localparam int VB = tbbp_pkg::INTERVAL_BITS;
   localparam int TB = tbbp_pkg::TOTAL_BITS;
   localparam int PB = tbbp_pkg::RSP_PTR_BITS;

   // configuration
   logic [SB-1:0]                 fresh_state_ff;
   logic [tbbp_pkg::MAP_BITS-1:0] output_map_ff;
   logic [VB-1:0]                 interval_length_ff;

   // update stage
   logic                      s1_valid_ff;
   logic                      s1_kind_ff;
   logic [IB-1:0]             s1_idx_ff;
   logic                      s1_taken_ff;
   tbbp_pkg::entry_type       rd_data_ff;

   // last write, for forwarding
   logic                      fwd_valid_ff;
   logic [IB-1:0]             fwd_idx_ff;
   logic [SB-1:0]             fwd_state_ff;

   // clearing pass
   logic                      sweep_ff;
   logic [IB-1:0]             sweep_idx_ff;

   // statistics
   logic [TB-1:0]             branch_total_ff, branch_total_in;
   logic [TB-1:0]             miss_total_ff, miss_total_in;
   logic [VB-1:0]             position_ff, position_in;
   logic [VB-1:0]             imiss_ff, imiss_in;

   // result queue
   tbbp_pkg::rsp_item_type    q_ff [tbbp_pkg::RSP_DEPTH];
   logic [PB-1:0]             q_wr_ff, q_rd_ff;
   logic [PB-1:0]             q_count_ff;

   tbbp_pkg::entry_type       table_mem [tbbp_pkg::TABLE_DEPTH];

   logic                      req_fire, rsp_fire, csr_fire;
   logic [IB-1:0]             req_idx;
   logic [PB:0]               inflight;
   logic                      s1_branch, s1_restart;
   tbbp_pkg::entry_type       cur_entry;
   logic [SB-1:0]             cur_state, new_state;
   logic                      pred, miss;
   logic [VB:0]               pos_next, limit;
   logic                      done;
   logic [VB-1:0]             imiss_sat;
   tbbp_pkg::rsp_item_type    s1_rsp;
   logic                      mem_we;
   logic [IB-1:0]             mem_wa;
   tbbp_pkg::entry_type       mem_wd;

   assign req_idx    = IB'(req.branch_address_low);
   assign s1_branch  = s1_valid_ff && (s1_kind_ff == tbbp_pkg::KIND_BRANCH);
   assign s1_restart = s1_valid_ff && (s1_kind_ff == tbbp_pkg::KIND_RESTART);
   assign inflight   = {1'b0, q_count_ff} + {{PB{1'b0}}, s1_valid_ff};

   assign req.ready = !sweep_ff && !s1_restart && (inflight < (PB+1)'(tbbp_pkg::RSP_DEPTH));
   assign csr.ready = 1'b1;
   assign req_fire  = req.valid && req.ready;
   assign rsp_fire  = rsp.valid && rsp.ready;
   assign csr_fire  = csr.valid && csr.ready;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         fresh_state_ff     <= tbbp_pkg::FRESH_STATE_RST;
         output_map_ff      <= tbbp_pkg::OUTPUT_MAP_RST;
         interval_length_ff <= tbbp_pkg::INTERVAL_LENGTH_RST;
      end else if (csr_fire) begin
         unique case (csr.index)
            tbbp_pkg::CSR_FRESH_STATE:     fresh_state_ff     <= csr.data[SB-1:0];
            tbbp_pkg::CSR_OUTPUT_MAP:      output_map_ff      <= csr.data[tbbp_pkg::MAP_BITS-1:0];
            tbbp_pkg::CSR_INTERVAL_LENGTH: interval_length_ff <= csr.data[VB-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- table ram
   always_comb begin
      if (sweep_ff) begin
         mem_we = 1'b1;
         mem_wa = sweep_idx_ff;
         mem_wd = '0;
      end else begin
         mem_we = s1_branch;
         mem_wa = s1_idx_ff;
         mem_wd = '{valid: 1'b1, state: new_state};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_wa] <= mem_wd;
      end
      if (req_fire) begin
         rd_data_ff <= table_mem[req_idx];
      end
   end

   // ---------------------------------------------------------------- update stage
   always_comb begin
      // the entry written last cycle has not reached the read data yet
      if (fwd_valid_ff && (fwd_idx_ff == s1_idx_ff)) begin
         cur_entry = '{valid: 1'b1, state: fwd_state_ff};
      end else begin
         cur_entry = rd_data_ff;
      end
      cur_state = cur_entry.valid ? cur_entry.state : fresh_state_ff;
      pred      = output_map_ff[cur_state];
      miss      = pred != s1_taken_ff;

      if (s1_taken_ff) begin
         new_state = (cur_state == tbbp_pkg::COUNTER_MAX) ? cur_state : cur_state + 1'b1;
      end else begin
         new_state = (cur_state == tbbp_pkg::COUNTER_MIN) ? cur_state : cur_state - 1'b1;
      end

      pos_next  = {1'b0, position_ff} + (VB+1)'(1);
      // zero length means a full 2^16 interval
      limit     = (interval_length_ff == '0) ? {1'b1, {VB{1'b0}}}
                                             : {1'b0, interval_length_ff};
      done      = pos_next >= limit;
      imiss_sat = (miss && (imiss_ff != '1)) ? imiss_ff + 1'b1 : imiss_ff;

      branch_total_in = (branch_total_ff != '1) ? branch_total_ff + 1'b1 : branch_total_ff;
      miss_total_in   = (miss && (miss_total_ff != '1)) ? miss_total_ff + 1'b1
                                                        : miss_total_ff;
      imiss_in        = done ? '0 : imiss_sat;
      position_in     = done ? '0 : pos_next[VB-1:0];

      if (s1_branch) begin
         s1_rsp = '{prediction:      pred,
                    mispredicted:    miss,
                    total_branches:  branch_total_in,
                    total_misses:    miss_total_in,
                    interval_done:   done,
                    interval_misses: done ? imiss_sat : '0};
      end else begin
         s1_rsp = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         fwd_valid_ff    <= 1'b0;
         sweep_ff        <= 1'b1;
         sweep_idx_ff    <= '0;
         branch_total_ff <= '0;
         miss_total_ff   <= '0;
         position_ff     <= '0;
         imiss_ff        <= '0;
      end else begin
         s1_valid_ff <= req_fire;
         if (s1_restart) begin
            fwd_valid_ff    <= 1'b0;
            sweep_ff        <= 1'b1;
            sweep_idx_ff    <= '0;
            branch_total_ff <= '0;
            miss_total_ff   <= '0;
            position_ff     <= '0;
            imiss_ff        <= '0;
         end else if (sweep_ff) begin
            fwd_valid_ff <= 1'b0;
            sweep_idx_ff <= sweep_idx_ff + 1'b1;
            if (sweep_idx_ff == '1) begin
               sweep_ff <= 1'b0;
            end
         end else if (s1_branch) begin
            fwd_valid_ff    <= 1'b1;
            branch_total_ff <= branch_total_in;
            miss_total_ff   <= miss_total_in;
            position_ff     <= position_in;
            imiss_ff        <= imiss_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_kind_ff  <= req.kind;
         s1_idx_ff   <= req_idx;
         s1_taken_ff <= req.taken;
      end
      if (s1_branch) begin
         fwd_idx_ff   <= s1_idx_ff;
         fwd_state_ff <= new_state;
      end
   end

   // ---------------------------------------------------------------- result queue
   always_ff @(posedge clock) begin
      if (reset) begin
         q_wr_ff    <= '0;
         q_rd_ff    <= '0;
         q_count_ff <= '0;
      end else begin
         if (s1_valid_ff) begin
            q_wr_ff <= (q_wr_ff == PB'(tbbp_pkg::RSP_DEPTH - 1)) ? '0 : q_wr_ff + 1'b1;
         end
         if (rsp_fire) begin
            q_rd_ff <= (q_rd_ff == PB'(tbbp_pkg::RSP_DEPTH - 1)) ? '0 : q_rd_ff + 1'b1;
         end
         if (s1_valid_ff && !rsp_fire) begin
            q_count_ff <= q_count_ff + 1'b1;
         end else if (!s1_valid_ff && rsp_fire) begin
            q_count_ff <= q_count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         q_ff[q_wr_ff] <= s1_rsp;
      end
   end

   assign rsp.valid           = q_count_ff != '0;
   assign rsp.prediction      = q_ff[q_rd_ff].prediction;
   assign rsp.mispredicted    = q_ff[q_rd_ff].mispredicted;
   assign rsp.total_branches  = q_ff[q_rd_ff].total_branches;
   assign rsp.total_misses    = q_ff[q_rd_ff].total_misses;
   assign rsp.interval_done   = q_ff[q_rd_ff].interval_done;
   assign rsp.interval_misses = q_ff[q_rd_ff].interval_misses;

endmodule

`default_nettype wire

>>> src/tbbp_checker.sv
// ----------------------------------------------------------------------------
// tbbp_checker
// Port-level checks of the branch predictor, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tbbp_checker (
   input wire                                 clock,
   input wire                                 reset,
   input wire                                 req_valid,
   input wire                                 req_ready,
   input wire                                 rsp_valid,
   input wire                                 rsp_ready,
   input wire                                 rsp_mispredicted,
   input wire [tbbp_pkg::TOTAL_BITS-1:0]      rsp_total_branches,
   input wire [tbbp_pkg::TOTAL_BITS-1:0]      rsp_total_misses,
   input wire                                 rsp_interval_done,
   input wire [tbbp_pkg::INTERVAL_BITS-1:0]   rsp_interval_misses
);

   // items accepted but not yet delivered
   logic [2:0] pending_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_ff + 3'(req_valid && req_ready) - 3'(rsp_valid && rsp_ready);
      end
   end

   // clearing pass holds off items right after reset
   a_clear_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready)
      else $error("item accepted during clearing pass");

   // no result without an outstanding item
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 3'd0)
      else $error("result with no item outstanding");

   a_miss_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_total_misses <= rsp_total_branches)
      else $error("more misses than branches");

   a_interval_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_interval_done) |-> rsp_interval_misses == '0)
      else $error("interval misses outside an interval end");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_mispredicted)
                                    && $stable(rsp_total_branches))
      else $error("stalled result changed");

endmodule

bind two_bit_branch_predictor_unit tbbp_checker u_tbbp_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req.valid),
   .req_ready           (req.ready),
   .rsp_valid           (rsp.valid),
   .rsp_ready           (rsp.ready),
   .rsp_mispredicted    (rsp.mispredicted),
   .rsp_total_branches  (rsp.total_branches),
   .rsp_total_misses    (rsp.total_misses),
   .rsp_interval_done   (rsp.interval_done),
   .rsp_interval_misses (rsp.interval_misses)
);

`default_nettype wire
